>>> design/cell_accumulator_with_stats_core_macros.svh
// Assertion macros used by the cell accumulator core design file.
// Define ASSERT_OFF to compile the checks away.
`ifndef CELL_ACCUMULATOR_WITH_STATS_CORE_MACROS_SVH
`define CELL_ACCUMULATOR_WITH_STATS_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define CAWS_ASSERT_IMPLIES(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("cell accumulator check failed");

// The consequent must hold in the cycle after the antecedent.
`define CAWS_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("cell accumulator check failed");

`else

`define CAWS_ASSERT_IMPLIES(label, clock, resetn, ante, cons)
`define CAWS_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

>>> design/caws_pkg.sv
package caws_pkg;

    // Field widths fixed by the interface.
    localparam int KIND_W = 3;
    localparam int INDEX_W = 12;
    localparam int DELTA_W = 9;
    localparam int CELL_W = 8;
    localparam int PCT_W = 17;
    localparam int AVG_W = 16;

    localparam int CELL_COUNT_DEF = 4096;

    // Normalized value constants in Q1.16.
    localparam logic [PCT_W-1:0] PCT_ONE = 17'h10000;
    localparam logic [PCT_W-1:0] PCT_HALF = 17'h08000;

    // Number of quotient bits produced for a normalized read.
    localparam int PCT_DIV_STEPS = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_STATS = 3'd2,
        KIND_READ = 3'd3,
        KIND_ARGMAX_ALL = 3'd4,
        KIND_ARGMAX_FOUR = 3'd5
    } kind_t;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_ADD = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_FOLD = 9'b000010000,
        S_FINISH = 9'b000100000,
        S_READ = 9'b001000000,
        S_DIV = 9'b010000000,
        S_OUT = 9'b100000000
    } state_t;

endpackage

>>> design/cell_accumulator_with_stats_core.sv
// Histogram cell accumulator. The cells live in one synchronous RAM of CELL_COUNT bytes
// with a registered read, and every operation is a read, a read-modify-write or a sweep
// over it, one item at a time. After reset the block runs a clearing pass over every
// cell before in_ready rises. An add reads the cell and writes it back, and a clear
// writes every cell to zero; neither gives a result. A read fetches the cell and goes
// through the bit-serial divider only when the value lies strictly between the kept
// minimum and maximum. Argmax over four indexes reads those four cells; argmax over the
// grid and the stats scan read every cell, all bound by the single RAM read port. The
// average comes from a constant reciprocal multiply. A finished result sits in an output
// register until it is taken; a result that finds the previous one still waiting holds
// the block until then, and the next item is taken when the block is back in its idle
// state.
`include "cell_accumulator_with_stats_core_macros.svh"

module cell_accumulator_with_stats_core #(
    parameter int CELL_COUNT = caws_pkg::CELL_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [caws_pkg::KIND_W-1:0]         kind,
    input  logic [caws_pkg::INDEX_W-1:0]        cell_index,
    input  logic signed [caws_pkg::DELTA_W-1:0] delta,
    input  logic [caws_pkg::INDEX_W-1:0]        second_index,
    input  logic [caws_pkg::INDEX_W-1:0]        third_index,
    input  logic [caws_pkg::INDEX_W-1:0]        fourth_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [caws_pkg::CELL_W-1:0]         cell_value,
    output logic [caws_pkg::PCT_W-1:0]          percent_q16,
    output logic [caws_pkg::CELL_W-1:0]         min_value,
    output logic [caws_pkg::CELL_W-1:0]         max_value,
    output logic [caws_pkg::AVG_W-1:0]          avg_q8,
    output logic [caws_pkg::INDEX_W-1:0]        best_index
);
    import caws_pkg::*;

    localparam int IDX_W = $clog2(CELL_COUNT);
    localparam int CLAMP_W = 17;
    localparam int SUM_W = CELL_W + IDX_W;
    localparam int DVD_W = SUM_W + 8;
    localparam int DRW = (IDX_W > CELL_W) ? IDX_W : CELL_W;
    localparam int DVS_W = DRW + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_COUNT - 1);
    localparam int RCP_SH = DVD_W + IDX_W;
    localparam int PROD_W = 2 * DVD_W + 2;
    // Rounded-up reciprocal of the cell count; the scaled sum stays below 2^DVD_W and
    // the cell count is at most 2^IDX_W, so the truncated product is the exact quotient.
    localparam logic [DVD_W+1:0] AVG_RCP = (DVD_W + 2)'(
        ((64'd1 << RCP_SH) + 64'(CELL_COUNT) - 64'd1) / 64'(CELL_COUNT));

    function automatic logic [IDX_W-1:0] clamp_idx(input logic [INDEX_W-1:0] raw);
        logic [CLAMP_W-1:0] wide;
        wide = CLAMP_W'(raw);
        if (wide >= CLAMP_W'(CELL_COUNT)) begin
            return LAST_IDX;
        end
        return IDX_W'(wide);
    endfunction

    // Cell storage.
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [CELL_W-1:0] rd_data_reg;

    // Control state.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [CELL_W-1:0] kept_min_reg, kept_min_next;
    logic [CELL_W-1:0] kept_max_reg, kept_max_next;
    logic             out_valid_reg, out_valid_next;

    // Item payload and working values.
    kind_t             op_reg, op_next;
    logic [IDX_W-1:0]  cand_reg [4];
    logic [IDX_W-1:0]  cand_next [4];
    logic [CELL_W-1:0] delta_reg, delta_next;
    logic [CELL_W-1:0] val_reg, val_next;
    logic [PCT_W-1:0]  pct_reg, pct_next;
    logic              rd_first_reg, rd_first_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CELL_W-1:0] fold_lo_reg, fold_lo_next;
    logic [CELL_W-1:0] fold_hi_reg, fold_hi_next;
    logic [SUM_W-1:0]  fold_sum_reg, fold_sum_next;
    logic [CELL_W-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;

    // Restoring divider for normalized reads.
    logic [DRW-1:0]   div_rem_reg, div_rem_next;
    logic [DVD_W-1:0] div_dvd_reg, div_dvd_next;
    logic [DVS_W-1:0] div_dvs_reg, div_dvs_next;
    logic [AVG_W-1:0] div_quo_reg, div_quo_next;
    logic [DVS_W-1:0] div_shift;
    logic             div_ge;
    logic [PROD_W-1:0] avg_prod;

    // Output register.
    logic [CELL_W-1:0]  cell_value_reg, cell_value_next;
    logic [PCT_W-1:0]   percent_reg, percent_next;
    logic [CELL_W-1:0]  min_value_reg, min_value_next;
    logic [CELL_W-1:0]  max_value_reg, max_value_next;
    logic [AVG_W-1:0]   avg_reg, avg_next;
    logic [INDEX_W-1:0] best_index_reg, best_index_next;

    logic             in_xfer;
    logic             scan_four;
    logic [IDX_W-1:0] scan_addr;
    logic [IDX_W-1:0] scan_last;
    logic             take;
    logic [CELL_W-1:0] diff;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign cell_value = cell_value_reg;
    assign percent_q16 = percent_reg;
    assign min_value = min_value_reg;
    assign max_value = max_value_reg;
    assign avg_q8 = avg_reg;
    assign best_index = best_index_reg;

    assign scan_four = (op_reg == KIND_ARGMAX_FOUR);
    assign scan_addr = scan_four ? cand_reg[cnt_reg[1:0]] : cnt_reg;
    assign scan_last = scan_four ? IDX_W'(3) : LAST_IDX;
    assign take = rd_first_reg || (rd_data_reg > best_val_reg);
    assign diff = kept_max_reg - kept_min_reg;

    assign div_shift = {div_rem_reg, div_dvd_reg[DVD_W-1]};
    assign div_ge = (div_shift >= div_dvs_reg);

    assign avg_prod = PROD_W'({fold_sum_reg, 8'h00}) * PROD_W'(AVG_RCP);

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = cand_reg[0];
        mem_wdata = rd_data_reg + delta_reg;
        mem_raddr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
            end
            S_ADD:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                mem_raddr = clamp_idx(cell_index);
            end
            S_SCAN:
            begin
                mem_raddr = scan_addr;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rd_valid_next = 1'b0;
        div_cnt_next = div_cnt_reg;
        kept_min_next = kept_min_reg;
        kept_max_next = kept_max_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_next = op_reg;
        cand_next = cand_reg;
        delta_next = delta_reg;
        val_next = val_reg;
        pct_next = pct_reg;
        rd_first_next = (cnt_reg == '0);
        rd_idx_next = scan_addr;
        fold_lo_next = fold_lo_reg;
        fold_hi_next = fold_hi_reg;
        fold_sum_next = fold_sum_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        div_rem_next = div_rem_reg;
        div_dvd_next = div_dvd_reg;
        div_dvs_next = div_dvs_reg;
        div_quo_next = div_quo_reg;
        cell_value_next = cell_value_reg;
        percent_next = percent_reg;
        min_value_next = min_value_reg;
        max_value_next = max_value_reg;
        avg_next = avg_reg;
        best_index_next = best_index_reg;

        // Fold one scanned cell into the running statistics.
        if (rd_valid_reg)
        begin
            if (rd_first_reg)
            begin
                fold_lo_next = rd_data_reg;
                fold_hi_next = rd_data_reg;
                fold_sum_next = SUM_W'(rd_data_reg);
            end
            else
            begin
                if (rd_data_reg < fold_lo_reg)
                begin
                    fold_lo_next = rd_data_reg;
                end
                if (rd_data_reg > fold_hi_reg)
                begin
                    fold_hi_next = rd_data_reg;
                end
                fold_sum_next = fold_sum_reg + SUM_W'(rd_data_reg);
            end
            if (take)
            begin
                best_val_next = rd_data_reg;
                best_idx_next = rd_idx_reg;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next = kind_t'(kind);
                    cand_next[0] = clamp_idx(cell_index);
                    cand_next[1] = clamp_idx(second_index);
                    cand_next[2] = clamp_idx(third_index);
                    cand_next[3] = clamp_idx(fourth_index);
                    delta_next = delta[CELL_W-1:0];
                    cnt_next = '0;
                    case (kind_t'(kind))
                        KIND_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        KIND_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        KIND_STATS, KIND_ARGMAX_ALL, KIND_ARGMAX_FOUR:
                        begin
                            state_next = S_SCAN;
                        end
                        KIND_READ:
                        begin
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                rd_valid_next = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == scan_last)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (op_reg == KIND_STATS)
                begin
                    kept_min_next = fold_lo_reg;
                    kept_max_next = fold_hi_reg;
                    div_quo_next = avg_prod[RCP_SH +: AVG_W];
                end
                state_next = S_OUT;
            end
            S_READ:
            begin
                val_next = rd_data_reg;
                if (diff == '0)
                begin
                    pct_next = PCT_HALF;
                    state_next = S_OUT;
                end
                else if (rd_data_reg <= kept_min_reg)
                begin
                    pct_next = '0;
                    state_next = S_OUT;
                end
                else if (rd_data_reg >= kept_max_reg)
                begin
                    pct_next = PCT_ONE;
                    state_next = S_OUT;
                end
                else
                begin
                    // Here 0 < v - min < diff, so the quotient fits in 16 bits.
                    div_rem_next = DRW'(rd_data_reg - kept_min_reg);
                    div_dvd_next = '0;
                    div_dvs_next = DVS_W'(diff);
                    div_cnt_next = CNT_W'(PCT_DIV_STEPS);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                div_rem_next = div_ge ? DRW'(div_shift - div_dvs_reg) : DRW'(div_shift);
                div_dvd_next = div_dvd_reg << 1;
                div_quo_next = {div_quo_reg[AVG_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == CNT_W'(1))
                begin
                    if (op_reg == KIND_READ)
                    begin
                        pct_next = {1'b0, div_quo_next};
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    cell_value_next = '0;
                    percent_next = '0;
                    min_value_next = '0;
                    max_value_next = '0;
                    avg_next = '0;
                    best_index_next = '0;
                    case (op_reg)
                        KIND_STATS:
                        begin
                            min_value_next = kept_min_reg;
                            max_value_next = kept_max_reg;
                            avg_next = div_quo_reg;
                        end
                        KIND_READ:
                        begin
                            cell_value_next = val_reg;
                            percent_next = pct_reg;
                        end
                        default:
                        begin
                            cell_value_next = best_val_reg;
                            best_index_next = INDEX_W'(best_idx_reg);
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
            kept_min_reg <= '0;
            kept_max_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rd_valid_reg <= rd_valid_next;
            div_cnt_reg <= div_cnt_next;
            kept_min_reg <= kept_min_next;
            kept_max_reg <= kept_max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        cand_reg <= cand_next;
        delta_reg <= delta_next;
        val_reg <= val_next;
        pct_reg <= pct_next;
        rd_first_reg <= rd_first_next;
        rd_idx_reg <= rd_idx_next;
        fold_lo_reg <= fold_lo_next;
        fold_hi_reg <= fold_hi_next;
        fold_sum_reg <= fold_sum_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        div_rem_reg <= div_rem_next;
        div_dvd_reg <= div_dvd_next;
        div_dvs_reg <= div_dvs_next;
        div_quo_reg <= div_quo_next;
        cell_value_reg <= cell_value_next;
        percent_reg <= percent_next;
        min_value_reg <= min_value_next;
        max_value_reg <= max_value_next;
        avg_reg <= avg_next;
        best_index_reg <= best_index_next;
    end

    // Scanned read data only arrives while a scan is running or draining.
    `CAWS_ASSERT_IMPLIES(a_fold_in_scan, clk, rst_n, rd_valid_reg, (state_reg == S_SCAN) || (state_reg == S_FOLD))
    // Both kept statistics come from the same scan.
    `CAWS_ASSERT_IMPLIES(a_kept_order, clk, rst_n, 1'b1, kept_min_reg <= kept_max_reg)
    // The last divider step hands over to the output stage.
    `CAWS_ASSERT_NEXT(a_div_done, clk, rst_n, (state_reg == S_DIV) && (div_cnt_reg == CNT_W'(1)), state_reg == S_OUT)
    // A normalized value never exceeds one.
    `CAWS_ASSERT_IMPLIES(a_pct_sat, clk, rst_n, out_valid_reg, percent_reg <= PCT_ONE)

endmodule

>>> bench/cell_accumulator_with_stats_core_tb.sv
`timescale 1ns / 100ps

module cell_accumulator_with_stats_core_tb;
    import caws_pkg::*;

    localparam int CELLS = CELL_COUNT_DEF;
    localparam int RANDOM_OPS = 1400;
    localparam int FILL_AT = 500;
    localparam int DRAIN_AT = 900;
    localparam int HOLD_AT = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 4400;
    localparam int QUIET_LIMIT = 30000;

    // Kinds outside the enum; the block is expected to swallow them silently.
    localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic [INDEX_W-1:0]        idx_a;
        logic signed [DELTA_W-1:0] delta;
        logic [INDEX_W-1:0]        idx_b;
        logic [INDEX_W-1:0]        idx_c;
        logic [INDEX_W-1:0]        idx_d;
        bit                        wait_drain;
    } hist_op_t;

    typedef struct {
        logic [CELL_W-1:0]  value;
        logic [PCT_W-1:0]   pct;
        logic [CELL_W-1:0]  lo_val;
        logic [CELL_W-1:0]  hi_val;
        logic [AVG_W-1:0]   avg;
        logic [INDEX_W-1:0] best;
    } hist_result_t;

    logic                        clk = 1'b1;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [KIND_W-1:0]           kind = '0;
    logic [INDEX_W-1:0]          cell_index = '0;
    logic signed [DELTA_W-1:0]   delta = '0;
    logic [INDEX_W-1:0]          second_index = '0;
    logic [INDEX_W-1:0]          third_index = '0;
    logic [INDEX_W-1:0]          fourth_index = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [CELL_W-1:0]           cell_value;
    logic [PCT_W-1:0]            percent_q16;
    logic [CELL_W-1:0]           min_value;
    logic [CELL_W-1:0]           max_value;
    logic [AVG_W-1:0]            avg_q8;
    logic [INDEX_W-1:0]          best_index;

    cell_accumulator_with_stats_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .cell_index   (cell_index),
        .delta        (delta),
        .second_index (second_index),
        .third_index  (third_index),
        .fourth_index (fourth_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cell_value   (cell_value),
        .percent_q16  (percent_q16),
        .min_value    (min_value),
        .max_value    (max_value),
        .avg_q8       (avg_q8),
        .best_index   (best_index)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Shadow copy of the grid and of the min/max kept by the last stats scan.
    logic [CELL_W-1:0] cell_model [CELLS];
    logic [CELL_W-1:0] kept_lo = '0;
    logic [CELL_W-1:0] kept_hi = '0;

    hist_op_t     pending_ops[$];
    hist_result_t awaited[$];
    hist_op_t     cur_op;
    hist_result_t want_res;
    int           ops_taken = 0;
    int           results_seen = 0;
    int           mismatches = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           quiet_cycles = 0;

    initial
    begin
        foreach (cell_model[i])
        begin
            cell_model[i] = '0;
        end
    end

    function automatic hist_op_t mk_op(logic [KIND_W-1:0] k, int a = 0, int d = 0,
                                       int b = 0, int c = 0, int e = 0);
        hist_op_t op;
        op.kind = k;
        op.idx_a = INDEX_W'(a);
        op.delta = DELTA_W'(d);
        op.idx_b = INDEX_W'(b);
        op.idx_c = INDEX_W'(c);
        op.idx_d = INDEX_W'(e);
        op.wait_drain = 1'b0;
        return op;
    endfunction

    // Most traffic lands on a few hot cells so that values build up and wrap.
    function automatic int pick_index();
        int hot [8] = '{0, 1, 2, 3, 2047, 2048, 4094, 4095};
        if ($urandom_range(9) < 7)
        begin
            return hot[$urandom_range(7)];
        end
        return $urandom_range(CELLS - 1);
    endfunction

    function automatic int rand_delta();
        return int'($urandom_range(510)) - 255;
    endfunction

    function automatic logic [PCT_W-1:0] norm_q16(logic [CELL_W-1:0] v);
        int span;
        int q;
        span = int'(kept_hi) - int'(kept_lo);
        if (span == 0)
        begin
            return PCT_HALF;
        end
        q = ((int'(v) - int'(kept_lo)) * 65536) / span;
        if (q < 0)
        begin
            q = 0;
        end
        if (q > 65536)
        begin
            q = 65536;
        end
        return PCT_W'(q);
    endfunction

    // Updates the shadow grid for one accepted operation and queues its result, if it gives one.
    task automatic apply_op(input hist_op_t op);
        hist_result_t       r;
        int                 lo;
        int                 hi;
        int                 total;
        int                 win;
        logic [INDEX_W-1:0] cand [4];
        r = '{default: '0};
        case (op.kind)
            KIND_ADD:
            begin
                cell_model[op.idx_a] = cell_model[op.idx_a] + op.delta[CELL_W-1:0];
            end
            KIND_CLEAR:
            begin
                foreach (cell_model[i])
                begin
                    cell_model[i] = '0;
                end
            end
            KIND_STATS:
            begin
                lo = cell_model[0];
                hi = cell_model[0];
                total = 0;
                foreach (cell_model[i])
                begin
                    if (cell_model[i] < lo)
                    begin
                        lo = cell_model[i];
                    end
                    if (cell_model[i] > hi)
                    begin
                        hi = cell_model[i];
                    end
                    total += cell_model[i];
                end
                kept_lo = CELL_W'(lo);
                kept_hi = CELL_W'(hi);
                r.lo_val = kept_lo;
                r.hi_val = kept_hi;
                r.avg = AVG_W'((total * 256) / CELLS);
                awaited.push_back(r);
            end
            KIND_READ:
            begin
                r.value = cell_model[op.idx_a];
                r.pct = norm_q16(r.value);
                awaited.push_back(r);
            end
            KIND_ARGMAX_ALL:
            begin
                win = 0;
                for (int i = 1; i < CELLS; i++)
                begin
                    if (cell_model[i] > cell_model[win])
                    begin
                        win = i;
                    end
                end
                r.value = cell_model[win];
                r.best = INDEX_W'(win);
                awaited.push_back(r);
            end
            KIND_ARGMAX_FOUR:
            begin
                cand = '{op.idx_a, op.idx_b, op.idx_c, op.idx_d};
                win = op.idx_a;
                for (int k = 1; k < 4; k++)
                begin
                    if (cell_model[cand[k]] > cell_model[win])
                    begin
                        win = cand[k];
                    end
                end
                r.value = cell_model[win];
                r.best = INDEX_W'(win);
                awaited.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] result %0d %s: got %0d, expected %0d",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // Driver: one transfer per accepted operation; payload is held while valid waits.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_op(cur_op);
                ops_taken <= ops_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() == 0
                    || ($urandom_range(99) < 7 && !(ops_taken >= 300 && ops_taken < 700))
                    || (pending_ops[0].wait_drain && awaited.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    cur_op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    kind <= cur_op.kind;
                    cell_index <= cur_op.idx_a;
                    delta <= cur_op.delta;
                    second_index <= cur_op.idx_b;
                    third_index <= cur_op.idx_c;
                    fourth_index <= cur_op.idx_d;
                end
            end
        end
    end

    // Long back-pressure on the result side, timed here so the input side fills up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (awaited.size() == 0)
                begin
                    report_mismatch("result with nothing awaited", 0, 0);
                end
                else
                begin
                    want_res = awaited.pop_front();
                    if (cell_value !== want_res.value)
                    begin
                        report_mismatch("cell_value", cell_value, want_res.value);
                    end
                    if (percent_q16 !== want_res.pct)
                    begin
                        report_mismatch("percent_q16", percent_q16, want_res.pct);
                    end
                    if (min_value !== want_res.lo_val)
                    begin
                        report_mismatch("min_value", min_value, want_res.lo_val);
                    end
                    if (max_value !== want_res.hi_val)
                    begin
                        report_mismatch("max_value", max_value, want_res.hi_val);
                    end
                    if (avg_q8 !== want_res.avg)
                    begin
                        report_mismatch("avg_q8", avg_q8, want_res.avg);
                    end
                    if (best_index !== want_res.best)
                    begin
                        report_mismatch("best_index", best_index, want_res.best);
                    end
                end
            end
            out_ready <= (hold_left == 0)
                && ((results_seen >= 250 && results_seen < 450) || $urandom_range(99) >= 7);
        end
    end

    // Watchdog on cycles without any transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("cell_accumulator_with_stats_core: mismatch");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        hist_op_t nxt;
        int       made;
        int       roll;
        bit       filled;

        // Directed part: empty grid, wraps, ties, stale statistics.
        pending_ops.push_back(mk_op(KIND_READ, 4095));
        pending_ops.push_back(mk_op(KIND_STATS));
        pending_ops.push_back(mk_op(KIND_ARGMAX_ALL));
        pending_ops.push_back(mk_op(KIND_ARGMAX_FOUR, 9, 0, 8, 7, 6));
        pending_ops.push_back(mk_op(KIND_ADD, 4095, 255));
        pending_ops.push_back(mk_op(KIND_ADD, 0, -255));
        pending_ops.push_back(mk_op(KIND_ADD, 0, -1));
        pending_ops.push_back(mk_op(KIND_ADD, 100, 200));
        pending_ops.push_back(mk_op(KIND_ADD, 100, 100));
        pending_ops.push_back(mk_op(KIND_ADD, 2730, 85));
        pending_ops.push_back(mk_op(KIND_ADD, 1365, 170));
        pending_ops.push_back(mk_op(KIND_ARGMAX_ALL));
        pending_ops.push_back(mk_op(KIND_STATS));
        pending_ops.push_back(mk_op(KIND_READ, 4095));
        pending_ops.push_back(mk_op(KIND_READ, 0));
        pending_ops.push_back(mk_op(KIND_READ, 100));
        pending_ops.push_back(mk_op(KIND_ARGMAX_FOUR, 100, 0, 4095, 4095, 0));
        pending_ops.push_back(mk_op(KIND_ARGMAX_FOUR, 1365, 0, 2730, 100, 1365));
        pending_ops.push_back(mk_op(KIND_RSVD_6, 4095, -1, 4095, 4095, 4095));
        pending_ops.push_back(mk_op(KIND_RSVD_7, 1365, 170, 2730, 1365, 2730));
        pending_ops.push_back(mk_op(KIND_CLEAR));
        pending_ops.push_back(mk_op(KIND_READ, 4095));
        pending_ops.push_back(mk_op(KIND_ADD, 7, 3));
        pending_ops.push_back(mk_op(KIND_STATS));
        pending_ops.push_back(mk_op(KIND_ADD, 7, 100));
        pending_ops.push_back(mk_op(KIND_READ, 7));

        made = 0;
        filled = 1'b0;
        while (made < RANDOM_OPS)
        begin
            if (made == FILL_AT && !filled)
            begin
                // Start from a drained, cleared grid, build a small pattern mostly on the
                // hot cells, check it, then clear again so reads see stale statistics.
                filled = 1'b1;
                nxt = mk_op(KIND_CLEAR);
                nxt.wait_drain = 1'b1;
                pending_ops.push_back(nxt);
                repeat (8)
                begin
                    pending_ops.push_back(mk_op(KIND_ADD, pick_index(),
                                                $urandom_range(255, 20)));
                end
                pending_ops.push_back(mk_op(KIND_STATS));
                repeat (6)
                begin
                    pending_ops.push_back(mk_op(KIND_READ, pick_index()));
                end
                pending_ops.push_back(mk_op(KIND_ARGMAX_ALL));
                pending_ops.push_back(mk_op(KIND_ARGMAX_FOUR, pick_index(), 0,
                                            pick_index(), pick_index(), pick_index()));
                pending_ops.push_back(mk_op(KIND_CLEAR));
                repeat (3)
                begin
                    pending_ops.push_back(mk_op(KIND_READ, $urandom_range(CELLS - 1)));
                end
                pending_ops.push_back(mk_op(KIND_STATS));
            end
            roll = $urandom_range(999);
            if (roll < 560)
            begin
                nxt = mk_op(KIND_ADD, pick_index(), rand_delta());
            end
            else if (roll < 760)
            begin
                nxt = mk_op(KIND_READ, pick_index(), rand_delta());
            end
            else if (roll < 880)
            begin
                nxt = mk_op(KIND_ARGMAX_FOUR, pick_index(), rand_delta(),
                            pick_index(), pick_index(), pick_index());
            end
            else if (roll < 910)
            begin
                nxt = mk_op(KIND_STATS, $urandom_range(4095), rand_delta());
            end
            else if (roll < 935)
            begin
                nxt = mk_op(KIND_ARGMAX_ALL, $urandom_range(4095), rand_delta());
            end
            else if (roll < 950)
            begin
                nxt = mk_op(KIND_CLEAR, $urandom_range(4095), rand_delta());
            end
            else
            begin
                nxt = mk_op($urandom_range(1) ? KIND_RSVD_7 : KIND_RSVD_6,
                            $urandom_range(4095), rand_delta(), $urandom_range(4095),
                            $urandom_range(4095), $urandom_range(4095));
            end
            if (made == DRAIN_AT)
            begin
                nxt.wait_drain = 1'b1;
            end
            pending_ops.push_back(nxt);
            if (nxt.kind != KIND_RSVD_6 && nxt.kind != KIND_RSVD_7)
            begin
                made++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("cell_accumulator_with_stats_core: match");
        end
        else
        begin
            $display("cell_accumulator_with_stats_core: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/caws_pkg.sv
design/cell_accumulator_with_stats_core.sv
bench/cell_accumulator_with_stats_core_tb.sv
